### hdl/int_to_decimal_ascii_assert.svh
// Assertion macros used by the checker module of this block.
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itda: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ITDA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itda: next-cycle check failed");

`endif

### hdl/itda_pkg.sv
package itda_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int NUM_DIGITS  = 10;
  localparam int DIGIT_IDX_W = 4;
  localparam int CNT_W       = 5;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift;
    logic prep;
    logic emit;
  } itda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic emit_last;
  } itda_sts_t;

endpackage

### hdl/itda_ctrl.sv
module itda_ctrl
  import itda_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  itda_sts_t sts_i,
  output itda_cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StPrep = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.shift = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(VALUE_W - 1)) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = StEmit;
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### hdl/itda_dp.sv
module itda_dp
  import itda_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [VALUE_W-1:0] value_i,
  input  itda_cmd_t          cmd_i,
  output itda_sts_t          sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CHAR_W-1:0]  out_char_o,
  output logic               out_last_o
);

  logic [VALUE_W-1:0]               bin_q, bin_d;
  logic [NUM_DIGITS-1:0][3:0]       bcd_q, bcd_d;
  logic [NUM_DIGITS-1:0][3:0]       adj;
  logic                             sign_q;
  logic [DIGIT_IDX_W-1:0]           ptr_q, ptr_top;
  logic                             out_valid_q;
  logic [CHAR_W-1:0]                char_q, next_char;
  logic                             last_q;
  logic [VALUE_W-1:0]               mag;

  assign mag = value_i[VALUE_W-1] ? (~value_i + 1'b1) : value_i;

  // Double dabble: correct every digit of five or more, then shift one bit in.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
    end
    {bcd_d, bin_d} = {adj[NUM_DIGITS-1:0], bin_q} << 1;
  end

  // The most significant non-zero digit; zero gives the units digit.
  always_comb begin
    ptr_top = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i] != 4'd0) begin
        ptr_top = DIGIT_IDX_W'(i);
      end
    end
  end

  assign next_char       = sign_q ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, bcd_q[ptr_q]});
  assign sts_o.emit_last = !sign_q && (ptr_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q  <= mag;
      bcd_q  <= '0;
      sign_q <= value_i[VALUE_W-1];
    end else if (cmd_i.shift) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
    if (cmd_i.prep) begin
      ptr_q <= ptr_top;
    end else if (cmd_i.emit) begin
      if (sign_q) begin
        sign_q <= 1'b0;
      end else begin
        ptr_q <= ptr_q - 1'b1;
      end
    end
    if (cmd_i.emit) begin
      char_q <= next_char;
      last_q <= sts_o.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule

### hdl/int_to_decimal_ascii.sv
// Each accepted item is loaded, converted by the bit-serial double dabble loop in the datapath,
// prepared, then emitted as 1 to 11 characters, each waiting for room in the output register.
// A new item is accepted while the previous item's last character waits in the output register.
// Reset is asynchronous and active low; it empties the output register and idles the controller.
module int_to_decimal_ascii
  import itda_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] value
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [CHAR_W-1:0]  m_axis_tdata,   // [7:0] character
  output logic               m_axis_tlast
);

  itda_cmd_t cmd;
  itda_sts_t sts;

  itda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itda_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

### hdl/itda_checker.sv
`include "int_to_decimal_ascii_assert.svh"

module itda_checker
  import itda_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [CHAR_W-1:0]  m_axis_tdata,
  input logic               m_axis_tlast
);

  `ITDA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `ITDA_ASSERT_IMP(a_char_set, clk_i, rst_ni, m_axis_tvalid, (m_axis_tdata == CHAR_MINUS) || ((m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= (CHAR_ZERO + 8'd9))))
  `ITDA_ASSERT_IMP(a_minus_not_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata == CHAR_MINUS), !m_axis_tlast)
  `ITDA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import itda_pkg::*;

  localparam int RANDOM_ITEMS = 390;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // Keeps the characters still owed by the block, oldest first.
  class char_scoreboard;
    text_char_t owed_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    // Works out the decimal text of an accepted value and queues it.
    function void add_value(logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [3:0]         digits[NUM_DIGITS];
      int                 ndig;
      text_char_t         c;
      mag  = v[VALUE_W-1] ? (~v + 1'b1) : v;
      ndig = 0;
      do begin
        digits[ndig] = 4'(mag % 10);
        mag          = mag / 10;
        ndig++;
      end while (mag != 0 && ndig < NUM_DIGITS);
      if (v[VALUE_W-1]) begin
        c.ch   = CHAR_MINUS;
        c.last = 1'b0;
        owed_chars.push_back(c);
      end
      for (int k = ndig - 1; k >= 0; k--) begin
        c.ch   = CHAR_ZERO + CHAR_W'(digits[k]);
        c.last = (k == 0);
        owed_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic last);
      text_char_t exp_c;
      if (owed_chars.size() == 0) begin
        $error("unexpected character %0d (last %0d) with nothing owed", ch, last);
        errors++;
        return;
      end
      exp_c = owed_chars.pop_front();
      if (ch !== exp_c.ch) begin
        $error("character: expected %0d, got %0d", exp_c.ch, ch);
        errors++;
      end
      if (last !== exp_c.last) begin
        $error("last: expected %0d, got %0d", exp_c.last, last);
        errors++;
      end
    endfunction

    function int owed();
      return owed_chars.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [VALUE_W-1:0] s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [CHAR_W-1:0]  m_axis_tdata;   // [7:0] character
  logic               m_axis_tlast;

  char_scoreboard sb = new();
  bit             sender_gaps;
  bit             receiver_stalls;
  bit             hold_request;
  int             cycles = 0;

  int_to_decimal_ascii dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("int_to_decimal_ascii: mismatch");
      $finish;
    end
  end

  // Offers one value and returns once the block has taken it.
  task automatic send_value(logic [VALUE_W-1:0] v);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.add_value(v);
  endtask

  // Mostly values of a chosen digit count so that every text length turns up.
  function automatic logic [VALUE_W-1:0] random_value();
    longint lo, hi, mag;
    int     ndig;
    if ($urandom_range(0, 3) == 0) return $urandom;
    ndig = $urandom_range(1, NUM_DIGITS);
    lo   = 1;
    for (int i = 1; i < ndig; i++) lo = lo * 10;
    hi = (ndig == NUM_DIGITS) ? 64'd2147483647 : lo * 10 - 1;
    if (ndig == 1) lo = 0;
    mag = lo + longint'($urandom_range(0, 32'(hi - lo)));
    if ($urandom_range(0, 1) == 0) return VALUE_W'(mag);
    if ($urandom_range(0, 15) == 0) return 32'h8000_0000;
    return VALUE_W'(-mag);
  endfunction

  // Receiver: stalls at random, and once holds off for a long stretch on request.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        stall = receiver_stalls ? $urandom_range(0, 5) : 0;
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_char(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin
    logic [VALUE_W-1:0] directed[$];
    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 -32'sd5, 32'd2147483647, 32'h8000_0000, -32'sd2147483647,
                 32'd1000000000, 32'd999999999, -32'sd1000000000, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'd12345, -32'sd98765, 32'd4000000, 32'h0000_FFFF};
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    hold_request    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_value(directed[i]);

    // Four phases: both sides idle, neither idles (with the long hold-off),
    // only the sender idles, only the receiver stalls.
    for (int phase = 0; phase < 4; phase++) begin
      sender_gaps     = (phase == 0 || phase == 2);
      receiver_stalls = (phase == 0 || phase == 3);
      if (phase == 1) hold_request = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) send_value(random_value());
    end
    s_axis_tvalid <= 1'b0;

    while (sb.owed() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("int_to_decimal_ascii: match");
    end else begin
      $display("int_to_decimal_ascii: mismatch");
    end
    $finish;
  end

endmodule
